>>> hw/rtl/txtovl_pkg.sv
// Shared types, constants and the font map of the text overlay character generator.
`default_nettype none

package txtovl_pkg;

  // Glyph cell size in pixels and width of the glyph atlas in cells.
  localparam int GLYPH_WIDTH   = 6;
  localparam int GLYPH_HEIGHT  = 8;
  localparam int ATLAS_COLUMNS = 26;

  // Field widths.
  localparam int CHAR_W      = 8;
  localparam int CURSOR_W    = 8;
  localparam int ORIGIN_W    = 10;
  localparam int SCREEN_W    = 12;
  localparam int TEX_W       = 8;
  localparam int COLOR_W     = 8;
  localparam int KIND_W      = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int OUT_DATA_W  = 2 * SCREEN_W + 2 * TEX_W + 3 * COLOR_W + CHAR_W;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Font map covers bytes ROM_FIRST up to ROM_FIRST + GLYPH_COUNT - 1.
  localparam int GLYPH_COUNT = 192;
  localparam int ROM_IDX_W   = $clog2(GLYPH_COUNT);
  localparam logic [CHAR_W-1:0] ROM_FIRST = 8'h20;
  localparam logic [CHAR_W:0]   ROM_END   = 9'(int'(ROM_FIRST) + GLYPH_COUNT);
  localparam logic [7:0]        NO_GLYPH  = 8'd255;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] CHAR_ESCAPE  = 8'h40;
  localparam logic [CHAR_W-1:0] CHAR_COLOR   = 8'h63;
  localparam logic [CHAR_W-1:0] CHAR_MARKER  = 8'h6D;
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam int TAB_BITS = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRAW_ENABLE   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MARKER_ENABLE = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_GLYPH  = 2'd0,
    KIND_COLOR  = 2'd1,
    KIND_MARKER = 2'd2
  } kind_t;

  // One command handed from the front to the back. arg is the atlas entry of
  // a glyph, the palette index of a color change or the code of a marker.
  typedef struct packed {
    kind_t               kind;
    logic [CURSOR_W-1:0] column;
    logic [CURSOR_W-1:0] row;
    logic [7:0]          arg;
  } cmd_t;

  // Atlas entry for each byte from ROM_FIRST on; entry = atlas row * 26 + column.
  localparam logic [7:0] GLYPH_MAP [GLYPH_COUNT] = '{
    NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, 8'd66, 8'd63, 8'd76,
    NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, 8'd125, 8'd62, 8'd126, 8'd75,
    8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd59,
    8'd60, 8'd61, 8'd65, NO_GLYPH, 8'd73, NO_GLYPH, 8'd70, 8'd74,
    NO_GLYPH, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
    8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14,
    8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22,
    8'd23, 8'd24, 8'd25, 8'd68, NO_GLYPH, 8'd69, 8'd64, NO_GLYPH,
    NO_GLYPH, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32,
    8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40,
    8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48,
    8'd49, 8'd50, 8'd51, NO_GLYPH, NO_GLYPH, NO_GLYPH, 8'd67, NO_GLYPH,
    8'd139, 8'd140, 8'd142, 8'd141, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH,
    NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH,
    NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH,
    NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH,
    NO_GLYPH, 8'd126, NO_GLYPH, NO_GLYPH, 8'd125, 8'd72, 8'd123, 8'd130,
    8'd131, 8'd132, 8'd133, 8'd134, 8'd136, 8'd137, 8'd138, 8'd135,
    8'd71, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84,
    8'd85, 8'd86, 8'd87, 8'd88, 8'd89, 8'd90, 8'd91, 8'd92,
    8'd93, 8'd94, 8'd95, 8'd96, 8'd97, 8'd98, 8'd99, 8'd100,
    8'd101, 8'd102, 8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109,
    8'd110, 8'd111, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117,
    8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd124, 8'd127, 8'd128
  };

  // Eight primary colors as {red, green, blue}.
  localparam logic [3*COLOR_W-1:0] PALETTE [8] = '{
    24'h000000, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
    24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
  };

endpackage

`default_nettype wire

>>> hw/rtl/text_overlay_character_generator_top.sv
// Text overlay character generator: front end, command queue and back end.
//
// Usage:
//   Text bytes arrive on the s_axis channel, one item per character; tuser set
//   means restart (cursor and escape state cleared, byte ignored). Each byte
//   yields zero or one result item on m_axis: a glyph draw, a color change or
//   a marker event, with the kind on tuser.
//   Registers origin_x, origin_y, draw_enable and marker_enable are written on
//   the cfg channel (index 0 to 3), which is always ready; write them only
//   while no items are in flight.
//   One byte is accepted every cycle while the four-entry command queue has
//   room. Each result passes through the queue and then the back end, a
//   three-stage pipeline of arithmetic and output register.
//   When the receiver stalls, the pipeline and then the queue fill; s_axis
//   tready drops only when the queue is full. Bytes that cause no result pass
//   through the front end alone.
//   Synchronous reset clears the cursor, escape state, registers and all
//   pipeline and queue contents.
`default_nettype none

module text_overlay_character_generator_top
  import txtovl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [CHAR_W-1:0]      s_axis_tdata,   // [7:0] character
  input  wire logic                   s_axis_tuser,   // [0] action
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [11:0] screen_x, [23:12] screen_y, [31:24] tex_s, [39:32] tex_t,
  // [47:40] color_red, [55:48] color_green, [63:56] color_blue, [71:64] marker_code
  output logic [OUT_DATA_W-1:0]       m_axis_tdata,
  output logic [KIND_W-1:0]           m_axis_tuser,   // [1:0] kind
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [ORIGIN_W-1:0] origin_x;
  logic [ORIGIN_W-1:0] origin_y;
  logic                cmd_push;
  cmd_t                cmd_in;
  logic                cmd_ready;
  logic                cmd_pop;
  logic                cmd_valid;
  cmd_t                cmd_out;

  txtovl_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in),
    .cmd_ready     (cmd_ready)
  );

  txtovl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (cmd_in),
    .push_ready (cmd_ready),
    .pop        (cmd_pop),
    .pop_valid  (cmd_valid),
    .pop_cmd    (cmd_out)
  );

  txtovl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd_out),
    .cmd_pop       (cmd_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> hw/rtl/txtovl_front.sv
// Front end: configuration registers, cursor and escape tracking, command generation.
`default_nettype none

module txtovl_front
  import txtovl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [CHAR_W-1:0]      s_axis_tdata,   // [7:0] character
  input  wire logic                   s_axis_tuser,   // [0] action (1 restart)
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [ORIGIN_W-1:0]         origin_x,
  output logic [ORIGIN_W-1:0]         origin_y,
  output logic                        cmd_push,
  output cmd_t                        cmd,
  input  wire logic                   cmd_ready
);

  typedef enum logic [3:0] {
    ESC_NORMAL = 4'b0001,
    ESC_AT     = 4'b0010,
    ESC_COLOR  = 4'b0100,
    ESC_MARK   = 4'b1000
  } esc_t;

  logic                draw_enable;
  logic                marker_enable;
  logic [CURSOR_W-1:0] column;
  logic [CURSOR_W-1:0] row;
  esc_t                esc;
  logic [CURSOR_W-1:0] column_next;
  logic [CURSOR_W-1:0] row_next;
  esc_t                esc_next;

  logic                accept;
  logic                in_rom;
  logic [ROM_IDX_W-1:0] rom_idx;
  logic [7:0]          rom_entry;
  logic [CURSOR_W:0]   tab_sum;
  logic [CURSOR_W:0]   tab_stop;
  logic [CURSOR_W-1:0] column_inc;
  logic [CURSOR_W-1:0] column_tab;
  logic [CURSOR_W-1:0] row_inc;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = cmd_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      draw_enable   <= 1'b0;
      marker_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X:      origin_x      <= cfg_data[ORIGIN_W-1:0];
        CFG_ORIGIN_Y:      origin_y      <= cfg_data[ORIGIN_W-1:0];
        CFG_DRAW_ENABLE:   draw_enable   <= cfg_data[0];
        CFG_MARKER_ENABLE: marker_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Space itself is in the map range but never drawn.
  assign in_rom    = ({1'b0, s_axis_tdata} > {1'b0, ROM_FIRST}) &&
                     ({1'b0, s_axis_tdata} < ROM_END);
  assign rom_idx   = in_rom ? ROM_IDX_W'(s_axis_tdata - ROM_FIRST) : '0;
  assign rom_entry = GLYPH_MAP[rom_idx];

  assign column_inc = (column == '1) ? column : column + 1'b1;
  assign row_inc    = (row == '1) ? row : row + 1'b1;
  assign tab_sum    = {1'b0, column} + (CURSOR_W+1)'(1 << TAB_BITS);
  assign tab_stop   = {tab_sum[CURSOR_W:TAB_BITS], TAB_BITS'(0)};
  assign column_tab = tab_stop[CURSOR_W] ? '1 : tab_stop[CURSOR_W-1:0];

  always_comb begin
    logic plain;
    plain       = 1'b0;
    column_next = column;
    row_next    = row;
    esc_next    = esc;
    cmd_push    = 1'b0;
    cmd.kind    = KIND_GLYPH;
    cmd.column  = column;
    cmd.row     = row;
    cmd.arg     = '0;
    if (accept) begin
      if (s_axis_tuser) begin
        column_next = '0;
        row_next    = '0;
        esc_next    = ESC_NORMAL;
      end else begin
        case (esc)
          ESC_AT: begin
            if (s_axis_tdata == CHAR_COLOR) begin
              esc_next = ESC_COLOR;
            end else if (s_axis_tdata == CHAR_MARKER) begin
              esc_next = ESC_MARK;
            end else begin
              // A broken escape falls back to ordinary text.
              esc_next = ESC_NORMAL;
              plain    = 1'b1;
            end
          end
          ESC_COLOR: begin
            esc_next = ESC_NORMAL;
            cmd_push = draw_enable;
            cmd.kind = KIND_COLOR;
            cmd.arg  = {5'b0, s_axis_tdata[2:0]};
          end
          ESC_MARK: begin
            esc_next = ESC_NORMAL;
            cmd_push = marker_enable;
            cmd.kind = KIND_MARKER;
            cmd.arg  = s_axis_tdata;
          end
          default: begin
            esc_next = ESC_NORMAL;
            plain    = 1'b1;
          end
        endcase
        if (plain) begin
          if (s_axis_tdata == CHAR_ESCAPE) begin
            esc_next = ESC_AT;
          end else if (s_axis_tdata < ROM_FIRST) begin
            if (s_axis_tdata == CHAR_TAB) begin
              column_next = column_tab;
            end else if (s_axis_tdata == CHAR_NEWLINE) begin
              column_next = '0;
              row_next    = row_inc;
            end
          end else begin
            cmd_push    = draw_enable && in_rom && (rom_entry != NO_GLYPH);
            cmd.kind    = KIND_GLYPH;
            cmd.arg     = rom_entry;
            column_next = column_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
      esc    <= ESC_NORMAL;
    end else begin
      column <= column_next;
      row    <= row_next;
      esc    <= esc_next;
    end
  end

`ifndef SYNTHESIS
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tuser) |=> (column == '0 && row == '0 && esc == ESC_NORMAL))
    else $error("restart did not clear cursor and escape state");
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> (accept && !s_axis_tuser))
    else $error("command pushed without an accepted character");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/txtovl_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module txtovl_queue
  import txtovl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire cmd_t  push_cmd,
  output logic       push_ready,
  input  wire logic  pop,
  output logic       pop_valid,
  output cmd_t       pop_cmd
);

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(QUEUE_DEPTH);

  cmd_t               slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != COUNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_FULL)
    else $error("queue count beyond depth");
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop after a pop");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/txtovl_back.sv
// Back end: position and atlas arithmetic pipeline with the output register.
`default_nettype none

module txtovl_back
  import txtovl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [ORIGIN_W-1:0]   origin_x,
  input  wire logic [ORIGIN_W-1:0]   origin_y,
  input  wire logic                  cmd_valid,
  input  wire cmd_t                  cmd,
  output logic                       cmd_pop,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [11:0] screen_x, [23:12] screen_y, [31:24] tex_s, [39:32] tex_t,
  // [47:40] color_red, [55:48] color_green, [63:56] color_blue, [71:64] marker_code
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [KIND_W-1:0]          m_axis_tuser    // [1:0] kind
);

  // Quotient by ATLAS_COLUMNS through a reciprocal; the estimate is low by at
  // most one for 8-bit entries, which one compare and subtract repairs.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (1 << RECIP_SHIFT) / ATLAS_COLUMNS;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD_W      = 8 + RECIP_W;
  localparam int COLPX_W     = $clog2(255 * GLYPH_WIDTH + 1);
  localparam int ROWPX_W     = $clog2(255 * GLYPH_HEIGHT + 1);
  // origin (at most 1023) plus 255 cells of at most 16 pixels stays below 2**13.
  localparam int SUM_W       = SCREEN_W + 1;
  localparam int REM_W       = 16;
  localparam logic [7:0] COLS = 8'(ATLAS_COLUMNS);

  // Stage 1.
  logic                s1_valid;
  kind_t               s1_kind;
  logic [7:0]          s1_arg;
  logic [7:0]          s1_q;
  logic [COLPX_W-1:0]  s1_col_px;
  logic [ROWPX_W-1:0]  s1_row_px;
  // Stage 2.
  logic                s2_valid;
  kind_t               s2_kind;
  logic [7:0]          s2_arg;
  logic [7:0]          s2_q;
  logic [7:0]          s2_r;
  logic [SCREEN_W-1:0] s2_x;
  logic [SCREEN_W-1:0] s2_y;

  logic                out_adv;
  logic                s2_adv;
  logic                s1_adv;
  logic [PROD_W-1:0]   q_prod;
  logic [REM_W-1:0]    rem_full;
  logic [7:0]          rem_raw;
  logic [SUM_W-1:0]    x_sum;
  logic [SUM_W-1:0]    y_sum;
  logic [15:0]         tex_s_full;
  logic [15:0]         tex_t_full;
  logic [3*COLOR_W-1:0] rgb;
  logic [OUT_DATA_W-1:0] tdata_next;
  kind_t               out_kind;

  assign out_adv = !m_axis_tvalid || m_axis_tready;
  assign s2_adv  = !s2_valid || out_adv;
  assign s1_adv  = !s1_valid || s2_adv;
  assign cmd_pop = cmd_valid && s1_adv;

  assign q_prod = PROD_W'(cmd.arg) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_kind   <= cmd.kind;
      s1_arg    <= cmd.arg;
      s1_q      <= q_prod[RECIP_SHIFT +: 8];
      s1_col_px <= COLPX_W'(cmd.column * COLPX_W'(GLYPH_WIDTH));
      s1_row_px <= ROWPX_W'(cmd.row * ROWPX_W'(GLYPH_HEIGHT));
    end
  end

  assign rem_full = REM_W'(s1_arg) - REM_W'(s1_q) * REM_W'(COLS);
  assign rem_raw  = rem_full[7:0];
  assign x_sum    = SUM_W'(origin_x) + SUM_W'(s1_col_px);
  assign y_sum    = SUM_W'(origin_y) + SUM_W'(s1_row_px);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_adv) begin
      s2_kind <= s1_kind;
      s2_arg  <= s1_arg;
      if (rem_raw >= COLS) begin
        s2_q <= s1_q + 1'b1;
        s2_r <= rem_raw - COLS;
      end else begin
        s2_q <= s1_q;
        s2_r <= rem_raw;
      end
      s2_x <= x_sum[SCREEN_W] ? '1 : x_sum[SCREEN_W-1:0];
      s2_y <= y_sum[SCREEN_W] ? '1 : y_sum[SCREEN_W-1:0];
    end
  end

  // Atlas texel origins wrap at 256.
  assign tex_s_full = 16'(s2_r) * 16'(GLYPH_WIDTH);
  assign tex_t_full = 16'(s2_q) * 16'(GLYPH_HEIGHT);
  assign rgb        = PALETTE[s2_arg[2:0]];

  // Fields that do not belong to the kind of the item stay zero.
  always_comb begin
    tdata_next = '0;
    case (s2_kind)
      KIND_GLYPH: begin
        tdata_next[11:0]  = s2_x;
        tdata_next[23:12] = s2_y;
        tdata_next[31:24] = tex_s_full[TEX_W-1:0];
        tdata_next[39:32] = tex_t_full[TEX_W-1:0];
      end
      KIND_COLOR: begin
        tdata_next[47:40] = rgb[23:16];
        tdata_next[55:48] = rgb[15:8];
        tdata_next[63:56] = rgb[7:0];
      end
      KIND_MARKER: begin
        tdata_next[11:0]  = s2_x;
        tdata_next[23:12] = s2_y;
        tdata_next[71:64] = s2_arg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_axis_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && out_adv) begin
      out_kind     <= s2_kind;
      m_axis_tdata <= tdata_next;
    end
  end

  assign m_axis_tuser = out_kind;

`ifndef SYNTHESIS
  a_pop_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> s1_valid)
    else $error("popped command did not enter the first stage");
`endif

endmodule

`default_nettype wire
